// ----- rtl/gfc_pkg.sv -----
// Package with the shared constants, codes and beat types of the GIF frame compositor.
`timescale 1ns / 1ps

package gfc_pkg;

   localparam int CANVAS_WORDS = 65536;
   localparam int PALETTE_SIZE = 256;
   localparam int CANVAS_AW    = $clog2(CANVAS_WORDS);
   localparam int PALETTE_AW   = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int COUNT_W      = $clog2(PALETTE_SIZE + 1);
   localparam int RGB_W        = 24;
   localparam int COORD_W      = 16;
   localparam int PROD_W       = 33;
   localparam int SUM_W        = 35;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;
   localparam int TRANSP_W     = 9;

   typedef enum logic [2:0] {
      OP_GLOBAL_WR = 3'd0,
      OP_LOCAL_WR  = 3'd1,
      OP_LOCAL_CLR = 3'd2,
      OP_PIXEL     = 3'd3,
      OP_END_FRAME = 3'd4,
      OP_READ      = 3'd5
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CANVAS_WIDTH      = 4'd0,
      CSR_FRAME_LEFT        = 4'd1,
      CSR_FRAME_TOP         = 4'd2,
      CSR_FRAME_WIDTH       = 4'd3,
      CSR_FRAME_HEIGHT      = 4'd4,
      CSR_TRANSPARENT_INDEX = 4'd5,
      CSR_DISPOSAL_MODE     = 4'd6,
      CSR_BACKGROUND_INDEX  = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      DISPOSE_NONE    = 2'd0,
      DISPOSE_KEEP    = 2'd1,
      DISPOSE_FILL    = 2'd2,
      DISPOSE_RESTORE = 2'd3
   } disposal_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [7:0]         palette_index;
      logic [RGB_W-1:0]   palette_rgb;
      logic [7:0]         color_index;
      logic [COORD_W-1:0] read_address;
   } req_type;

   typedef struct packed {
      logic [RGB_W-1:0] read_rgb;
      logic             status;
   } rsp_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic resp_plain;
      logic resp_drop;
      logic pix_write;
      logic resp_read;
      logic disp_init;
      logic disp_read;
      logic disp_write;
      logic copy_step;
      logic copy_done;
   } cmd_type;

   typedef struct packed {
      logic pix_outside;
      logic disp_skip;
      logic disp_beyond;
      logic disp_last;
      logic sweep_last;
   } stat_type;

endpackage

// ----- rtl/gfc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gfc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gfc_ctrl.sv -----
// Controller state machine that sequences items, disposal walks and canvas sweeps.
`timescale 1ns / 1ps

module gfc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        operation,
   input  gfc_pkg::stat_type stat,
   output logic              busy,
   output gfc_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_CLEAR     = 9'b000000001,
      S_IDLE      = 9'b000000010,
      S_PIX       = 9'b000000100,
      S_READ      = 9'b000001000,
      S_DISP_INIT = 9'b000010000,
      S_DISP_RD   = 9'b000100000,
      S_DISP_WR   = 9'b001000000,
      S_COPY      = 9'b010000000,
      S_COPY_TAIL = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (gfc_pkg::op_type'(operation))
                  gfc_pkg::OP_PIXEL: begin
                     if (stat.pix_outside) begin
                        cmd.resp_plain = 1'b1;
                        cmd.resp_drop  = 1'b1;
                     end else begin
                        state_in = S_PIX;
                     end
                  end
                  gfc_pkg::OP_END_FRAME: state_in = S_DISP_INIT;
                  gfc_pkg::OP_READ:      state_in = S_READ;
                  default:               cmd.resp_plain = 1'b1;
               endcase
            end
         end
         S_PIX: begin
            cmd.pix_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ: begin
            cmd.resp_read = 1'b1;
            state_in      = S_IDLE;
         end
         S_DISP_INIT: begin
            cmd.disp_init = 1'b1;
            state_in      = stat.disp_skip ? S_COPY : S_DISP_RD;
         end
         S_DISP_RD: begin
            if (stat.disp_beyond) begin
               state_in = S_COPY;
            end else begin
               cmd.disp_read = 1'b1;
               state_in      = S_DISP_WR;
            end
         end
         S_DISP_WR: begin
            cmd.disp_write = 1'b1;
            state_in       = stat.disp_last ? S_COPY : S_DISP_RD;
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_COPY_TAIL;
            end
         end
         S_COPY_TAIL: begin
            cmd.copy_done = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // A canvas write of the disposal walk always follows its saved-canvas read.
   a_disp_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DISP_WR |-> $past(state_ff == S_DISP_RD))
      else $error("disposal write without preceding read");

   // The pixel write stage is entered only from an accepted beat.
   a_pix_from_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PIX |-> $past(state_ff == S_IDLE && start))
      else $error("pixel stage without accepted beat");

endmodule

// ----- rtl/gfc_datapath.sv -----
// Datapath with registers, palettes, canvas memories, address arithmetic and result register.
`timescale 1ns / 1ps

module gfc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gfc_pkg::req_type                     req_data,
   input  logic                                 csr_valid,
   input  logic [gfc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gfc_pkg::CSR_DATA_W-1:0]       csr_data,
   input  gfc_pkg::cmd_type                     cmd,
   output gfc_pkg::stat_type                    stat,
   output logic                                 rsp_valid,
   output gfc_pkg::rsp_type                     rsp_data
);

   // Configuration registers.
   logic [gfc_pkg::COORD_W-1:0]  canvas_width_ff, frame_left_ff, frame_top_ff;
   logic [gfc_pkg::COORD_W-1:0]  frame_width_ff, frame_height_ff;
   logic [gfc_pkg::TRANSP_W-1:0] transparent_ff;
   logic [1:0]                   disposal_ff;
   logic [7:0]                   background_ff;

   // Item state.
   logic [gfc_pkg::COUNT_W-1:0]  global_count_ff, local_count_ff;
   logic [gfc_pkg::COORD_W-1:0]  pix_col_ff, pix_row_ff;
   gfc_pkg::req_type             item_ff;
   logic                         read_ok_ff;
   logic [gfc_pkg::PROD_W-1:0]   product_ff;

   // Disposal walk and sweep.
   logic [gfc_pkg::SUM_W-1:0]    row_base_ff;
   logic [gfc_pkg::COORD_W-1:0]  walk_col_ff, walk_row_ff;
   logic [gfc_pkg::RGB_W-1:0]    fill_ff;
   logic [gfc_pkg::CANVAS_AW-1:0] disp_addr_ff;
   logic [gfc_pkg::CANVAS_AW-1:0] sweep_ff;
   logic                         copy_wr_en_ff;
   logic [gfc_pkg::CANVAS_AW-1:0] copy_addr_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   gfc_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   gfc_pkg::op_type              op;
   logic                         pidx_ok;
   logic [gfc_pkg::COORD_W-1:0]  mult_row;
   logic [gfc_pkg::PROD_W-1:0]   product_in;
   logic [gfc_pkg::SUM_W-1:0]    pix_addr, disp_addr;
   logic                         pix_beyond, transparent_hit;
   logic                         local_hit, global_hit;
   logic [gfc_pkg::RGB_W-1:0]    color;
   logic [gfc_pkg::COORD_W:0]    pix_col_next, walk_col_next, walk_row_next;
   logic                         row_end;

   logic [gfc_pkg::PALETTE_AW-1:0] gpal_raddr;
   logic [gfc_pkg::RGB_W-1:0]      gpal_rd, lpal_rd;
   logic                           gpal_we, lpal_we;

   logic                           canvas_we, canvas_re;
   logic [gfc_pkg::CANVAS_AW-1:0]  canvas_waddr, canvas_raddr;
   logic [gfc_pkg::RGB_W-1:0]      canvas_wdata, canvas_rd;
   logic                           saved_we;
   logic [gfc_pkg::CANVAS_AW-1:0]  saved_waddr, saved_raddr;
   logic [gfc_pkg::RGB_W-1:0]      saved_wdata, saved_rd;

   assign op      = gfc_pkg::op_type'(req_data.operation);
   assign pidx_ok = 9'(req_data.palette_index) < 9'(gfc_pkg::PALETTE_SIZE);

   assign mult_row   = (op == gfc_pkg::OP_PIXEL) ? pix_row_ff : '0;
   assign product_in = 33'(17'(frame_top_ff) + 17'(mult_row)) * 33'(canvas_width_ff);

   assign pix_addr   = gfc_pkg::SUM_W'(product_ff) + gfc_pkg::SUM_W'(frame_left_ff)
                       + gfc_pkg::SUM_W'(pix_col_ff);
   assign pix_beyond = pix_addr >= gfc_pkg::SUM_W'(gfc_pkg::CANVAS_WORDS);
   // A transparent index with its sign bit set matches no pixel.
   assign transparent_hit = !transparent_ff[8] &&
                            (transparent_ff[7:0] == item_ff.color_index);
   assign local_hit  = 9'(item_ff.color_index) < 9'(local_count_ff);
   assign global_hit = 9'(item_ff.color_index) < 9'(global_count_ff);
   assign color      = local_hit ? lpal_rd : (global_hit ? gpal_rd : '0);
   assign pix_col_next = 17'(pix_col_ff) + 17'd1;

   assign disp_addr     = row_base_ff + gfc_pkg::SUM_W'(walk_col_ff);
   assign walk_col_next = 17'(walk_col_ff) + 17'd1;
   assign walk_row_next = 17'(walk_row_ff) + 17'd1;
   assign row_end       = walk_col_next == 17'(frame_width_ff);

   always_comb begin
      stat.pix_outside = (pix_row_ff >= frame_height_ff) || (pix_col_ff >= frame_width_ff);
      stat.disp_skip   = !(disposal_ff == gfc_pkg::DISPOSE_FILL ||
                           disposal_ff == gfc_pkg::DISPOSE_RESTORE) ||
                         (frame_width_ff == '0) || (frame_height_ff == '0);
      stat.disp_beyond = disp_addr >= gfc_pkg::SUM_W'(gfc_pkg::CANVAS_WORDS);
      // With a zero stride every row lands on the same words, so one row is enough.
      stat.disp_last   = row_end && ((walk_row_next == 17'(frame_height_ff)) ||
                                     (canvas_width_ff == '0));
      stat.sweep_last  = sweep_ff == gfc_pkg::CANVAS_AW'(gfc_pkg::CANVAS_WORDS - 1);
   end

   // Palette memories.
   assign gpal_we    = cmd.accept && (op == gfc_pkg::OP_GLOBAL_WR) && pidx_ok;
   assign lpal_we    = cmd.accept && (op == gfc_pkg::OP_LOCAL_WR) && pidx_ok;
   assign gpal_raddr = (op == gfc_pkg::OP_END_FRAME) ?
                       gfc_pkg::PALETTE_AW'(background_ff) :
                       gfc_pkg::PALETTE_AW'(req_data.color_index);

   gfc_ram #(.WIDTH(gfc_pkg::RGB_W), .DEPTH(gfc_pkg::PALETTE_SIZE)) u_global_palette (
      .clock   (clock),
      .wr_en   (gpal_we),
      .wr_addr (gfc_pkg::PALETTE_AW'(req_data.palette_index)),
      .wr_data (req_data.palette_rgb),
      .rd_en   (cmd.accept),
      .rd_addr (gpal_raddr),
      .rd_data (gpal_rd)
   );

   gfc_ram #(.WIDTH(gfc_pkg::RGB_W), .DEPTH(gfc_pkg::PALETTE_SIZE)) u_local_palette (
      .clock   (clock),
      .wr_en   (lpal_we),
      .wr_addr (gfc_pkg::PALETTE_AW'(req_data.palette_index)),
      .wr_data (req_data.palette_rgb),
      .rd_en   (cmd.accept),
      .rd_addr (gfc_pkg::PALETTE_AW'(req_data.color_index)),
      .rd_data (lpal_rd)
   );

   // Canvas and saved canvas memories.
   always_comb begin
      canvas_we = cmd.clear_step || cmd.disp_write ||
                  (cmd.pix_write && !pix_beyond && !transparent_hit);
      if (cmd.clear_step) begin
         canvas_waddr = sweep_ff;
         canvas_wdata = '0;
      end else if (cmd.pix_write) begin
         canvas_waddr = gfc_pkg::CANVAS_AW'(pix_addr);
         canvas_wdata = color;
      end else begin
         canvas_waddr = disp_addr_ff;
         canvas_wdata = (disposal_ff == gfc_pkg::DISPOSE_FILL) ? fill_ff : saved_rd;
      end
      canvas_re    = (cmd.accept && (op == gfc_pkg::OP_READ)) || cmd.copy_step;
      canvas_raddr = cmd.copy_step ? sweep_ff :
                     gfc_pkg::CANVAS_AW'(req_data.read_address);

      saved_we    = cmd.clear_step || copy_wr_en_ff;
      saved_waddr = cmd.clear_step ? sweep_ff : copy_addr_ff;
      saved_wdata = cmd.clear_step ? '0 : canvas_rd;
      saved_raddr = gfc_pkg::CANVAS_AW'(disp_addr);
   end

   gfc_ram #(.WIDTH(gfc_pkg::RGB_W), .DEPTH(gfc_pkg::CANVAS_WORDS)) u_canvas (
      .clock   (clock),
      .wr_en   (canvas_we),
      .wr_addr (canvas_waddr),
      .wr_data (canvas_wdata),
      .rd_en   (canvas_re),
      .rd_addr (canvas_raddr),
      .rd_data (canvas_rd)
   );

   gfc_ram #(.WIDTH(gfc_pkg::RGB_W), .DEPTH(gfc_pkg::CANVAS_WORDS)) u_saved_canvas (
      .clock   (clock),
      .wr_en   (saved_we),
      .wr_addr (saved_waddr),
      .wr_data (saved_wdata),
      .rd_en   (cmd.disp_read),
      .rd_addr (saved_raddr),
      .rd_data (saved_rd)
   );

   // Result beat.
   always_comb begin
      rsp_valid_in         = cmd.resp_plain || cmd.pix_write || cmd.resp_read || cmd.copy_done;
      rsp_data_in.read_rgb = (cmd.resp_read && read_ok_ff) ? canvas_rd : '0;
      rsp_data_in.status   = (cmd.resp_plain && cmd.resp_drop) ||
                             (cmd.pix_write && pix_beyond);
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= 16'd256;
         frame_left_ff    <= '0;
         frame_top_ff     <= '0;
         frame_width_ff   <= '0;
         frame_height_ff  <= '0;
         transparent_ff   <= '1;
         disposal_ff      <= gfc_pkg::DISPOSE_NONE;
         background_ff    <= '0;
         global_count_ff  <= '0;
         local_count_ff   <= '0;
         pix_col_ff       <= '0;
         pix_row_ff       <= '0;
         sweep_ff         <= '0;
         copy_wr_en_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               gfc_pkg::CSR_CANVAS_WIDTH:      canvas_width_ff <= csr_data;
               gfc_pkg::CSR_FRAME_LEFT:        frame_left_ff   <= csr_data;
               gfc_pkg::CSR_FRAME_TOP:         frame_top_ff    <= csr_data;
               gfc_pkg::CSR_FRAME_WIDTH:       frame_width_ff  <= csr_data;
               gfc_pkg::CSR_FRAME_HEIGHT:      frame_height_ff <= csr_data;
               gfc_pkg::CSR_TRANSPARENT_INDEX: transparent_ff  <= csr_data[gfc_pkg::TRANSP_W-1:0];
               gfc_pkg::CSR_DISPOSAL_MODE:     disposal_ff     <= csr_data[1:0];
               gfc_pkg::CSR_BACKGROUND_INDEX:  background_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         if (gpal_we && (9'(global_count_ff) < 9'(req_data.palette_index) + 9'd1)) begin
            global_count_ff <= gfc_pkg::COUNT_W'(9'(req_data.palette_index) + 9'd1);
         end
         if (lpal_we && (9'(local_count_ff) < 9'(req_data.palette_index) + 9'd1)) begin
            local_count_ff <= gfc_pkg::COUNT_W'(9'(req_data.palette_index) + 9'd1);
         end
         if (cmd.accept && (op == gfc_pkg::OP_LOCAL_CLR)) begin
            local_count_ff <= '0;
         end
         if (cmd.pix_write) begin
            if (pix_col_next >= 17'(frame_width_ff)) begin
               pix_col_ff <= '0;
               pix_row_ff <= pix_row_ff + 16'd1;
            end else begin
               pix_col_ff <= pix_col_next[gfc_pkg::COORD_W-1:0];
            end
         end
         if (cmd.copy_done) begin
            pix_col_ff <= '0;
            pix_row_ff <= '0;
         end
         if (cmd.clear_step || cmd.copy_step) begin
            sweep_ff <= stat.sweep_last ? '0 : sweep_ff + 1'b1;
         end
         copy_wr_en_ff <= cmd.copy_step;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff    <= req_data;
         read_ok_ff <= 32'(req_data.read_address) < gfc_pkg::CANVAS_WORDS;
         product_ff <= product_in;
      end
      if (cmd.disp_init) begin
         row_base_ff <= gfc_pkg::SUM_W'(product_ff) + gfc_pkg::SUM_W'(frame_left_ff);
         walk_col_ff <= '0;
         walk_row_ff <= '0;
         fill_ff     <= (9'(background_ff) < 9'(global_count_ff)) ? gpal_rd : '0;
      end
      if (cmd.disp_read) begin
         disp_addr_ff <= gfc_pkg::CANVAS_AW'(disp_addr);
      end
      if (cmd.disp_write) begin
         if (row_end) begin
            walk_col_ff <= '0;
            walk_row_ff <= walk_row_next[gfc_pkg::COORD_W-1:0];
            row_base_ff <= row_base_ff + gfc_pkg::SUM_W'(canvas_width_ff);
         end else begin
            walk_col_ff <= walk_col_next[gfc_pkg::COORD_W-1:0];
         end
      end
      copy_addr_ff <= sweep_ff;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Only one source drives the canvas write port in a cycle.
   a_canvas_wr_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.pix_write, cmd.disp_write}))
      else $error("canvas write port contention");

   // Saved-canvas copy writes come in the cycle after a canvas read of the sweep.
   a_copy_follows_read: assert property (@(posedge clock) disable iff (reset)
      copy_wr_en_ff |-> $past(cmd.copy_step))
      else $error("copy write without sweep read");

endmodule

// ----- rtl/gif_frame_compositor.sv -----
// Top level of the GIF frame compositor: controller, datapath and configuration port.
// Palette, clear, unused and dropped pixel items: result in the cycle after accept,
// one per cycle. Written pixel and read items: result registered after the pixel
// or read state, which holds off the next item. End of frame: result after the
// disposal walk (a read and a write per rectangle position, up to the canvas end)
// and the canvas copy. Synchronous reset clears all CANVAS_WORDS (65536) words of both
// canvases; busy is high. Each result is a one-cycle strobe; the receiver cannot stall.
`timescale 1ns / 1ps

module gif_frame_compositor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  gfc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output gfc_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gfc_pkg::CSR_DATA_W-1:0]  csr_data
);

   gfc_pkg::cmd_type  cmd;
   gfc_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   gfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd)
   );

   gfc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
